// ===== hdl/bitmap_shape_rasterizer_assert.svh =====
// assertion macros for the rasterizer
`ifndef BITMAP_SHAPE_RASTERIZER_ASSERT_SVH
`define BITMAP_SHAPE_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS

`define BSR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rasterizer check failed");

`define BSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rasterizer check failed");

`else

`define BSR_ASSERT_SAME(label, clk, rst_n, ante, cons)

`define BSR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/bsr_pkg.sv =====
package bsr_pkg;

    localparam int DEF_CANVAS_ROWS = 32;
    localparam int DEF_CANVAS_COLS = 64;

    localparam int CMD_W   = 3;
    localparam int COORD_W = 6;
    localparam int IDX_W   = 5;
    localparam int PIX_W   = 64;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_CLEAR    = 3'd0;
    localparam cmd_t CMD_RECT     = 3'd1;
    localparam cmd_t CMD_LINE     = 3'd2;
    localparam cmd_t CMD_TRIANGLE = 3'd3;
    localparam cmd_t CMD_CIRCLE   = 3'd4;
    localparam cmd_t CMD_DISPLAY  = 3'd5;

    typedef struct packed {
        logic load;
        logic clear_all;
        logic issue;
    } ctl_t;

    // columns lo..hi inclusive, hi may run past the word
    function automatic logic [PIX_W-1:0] span_bits(
        input logic [COORD_W-1:0] lo,
        input logic [COORD_W:0]   hi
    );
        logic [PIX_W-1:0] bits;
        logic [COORD_W:0] col;
        bits = '0;
        for (int j = 0; j < PIX_W; j++)
        begin
            col = (COORD_W+1)'(j);
            bits[j] = (col >= {1'b0, lo}) && (col <= hi);
        end
        return bits;
    endfunction

endpackage

// ===== hdl/bsr_ram.sv =====
module bsr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bsr_ctrl.sv =====
module bsr_ctrl #(
    parameter int CANVAS_ROWS = bsr_pkg::DEF_CANVAS_ROWS,
    parameter int ROW_W = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  bsr_pkg::cmd_t       cmd,
    output logic                busy,
    output bsr_pkg::ctl_t       ctl,
    output logic [ROW_W-1:0]    rd_row
);

    import bsr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(CANVAS_ROWS - 1);

    logic [1:0]       state_reg, state_next;
    logic [ROW_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             is_walk;

    assign accept = start && (state_reg == ST_IDLE);
    assign is_walk = (cmd == CMD_RECT) || (cmd == CMD_LINE) || (cmd == CMD_TRIANGLE)
                  || (cmd == CMD_CIRCLE) || (cmd == CMD_DISPLAY);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept && is_walk)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ROW)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign rd_row = cnt_reg;
    assign ctl.load = accept && is_walk;
    assign ctl.clear_all = accept && (cmd == CMD_CLEAR);
    assign ctl.issue = (state_reg == ST_RUN);

endmodule

// ===== hdl/bsr_datapath.sv =====
module bsr_datapath #(
    parameter int CANVAS_ROWS = bsr_pkg::DEF_CANVAS_ROWS,
    parameter int CANVAS_COLS = bsr_pkg::DEF_CANVAS_COLS,
    parameter int ROW_W = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bsr_pkg::ctl_t                 ctl,
    input  logic [ROW_W-1:0]              rd_row,
    input  bsr_pkg::cmd_t                 cmd,
    input  logic [bsr_pkg::COORD_W-1:0]   top_row,
    input  logic [bsr_pkg::COORD_W-1:0]   left_col,
    input  logic [bsr_pkg::COORD_W-1:0]   extent_a,
    input  logic [bsr_pkg::COORD_W-1:0]   extent_b,
    output logic                          strobe,
    output logic [bsr_pkg::IDX_W-1:0]     row_index,
    output logic [bsr_pkg::PIX_W-1:0]     row_pixels,
    output logic                          last_row
);

    import bsr_pkg::*;

    localparam logic [PIX_W:0] ONE_W = (PIX_W+1)'(1);
    localparam logic [PIX_W-1:0] COL_MASK = PIX_W'((ONE_W << CANVAS_COLS) - ONE_W);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(CANVAS_ROWS - 1);
    localparam int SQ_W = 2 * COORD_W;
    localparam int D_W = SQ_W + 1;

    // command word held for the walk
    cmd_t               cmd_reg;
    logic [COORD_W-1:0] top_reg, left_reg, ea_reg, eb_reg;
    logic [D_W-1:0]     lo_reg, hi_reg;
    logic [SQ_W-1:0]    rsq;

    // read stage
    logic [COORD_W:0]   row7, top7, dx;
    logic [COORD_W-1:0] dx6;
    logic [SQ_W-1:0]    dx2_next;

    // modify-write stage
    logic               s2_valid_reg;
    logic [ROW_W-1:0]   s2_row_reg;
    logic [SQ_W-1:0]    dx2_reg;
    logic               rvalid_reg;
    logic [CANVAS_ROWS-1:0] row_valid_reg;

    logic [PIX_W-1:0]   ram_rdata, old_row, draw_mask, wdata;
    logic [PIX_W-1:0]   rect_mask, line_mask, tri_mask, circ_mask;
    logic [COORD_W:0]   row7s, band_end;
    logic               in_band, we;

    // output word
    logic               strobe_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic               last_reg;

    assign rsq = ea_reg * ea_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            top_reg <= top_row;
            left_reg <= left_col;
            ea_reg <= extent_a;
            eb_reg <= extent_b;
        end
        lo_reg <= {1'b0, rsq} - {{(D_W-COORD_W){1'b0}}, ea_reg};
        hi_reg <= {1'b0, rsq} + {{(D_W-COORD_W){1'b0}}, ea_reg};
    end

    assign row7 = (COORD_W+1)'(rd_row);
    assign top7 = {1'b0, top_reg};
    assign dx = (row7 >= top7) ? (row7 - top7) : (top7 - row7);
    assign dx6 = dx[COORD_W-1:0];
    assign dx2_next = dx6 * dx6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            s2_valid_reg <= ctl.issue;
            if (ctl.clear_all)
            begin
                row_valid_reg <= '0;
            end
            else if (we)
            begin
                row_valid_reg[s2_row_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s2_row_reg <= rd_row;
        dx2_reg <= dx2_next;
        rvalid_reg <= row_valid_reg[rd_row];
    end

    bsr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (CANVAS_ROWS),
        .ADDR_W(ROW_W)
    ) u_canvas (
        .clk  (clk),
        .we   (we),
        .waddr(s2_row_reg),
        .wdata(wdata),
        .raddr(rd_row),
        .rdata(ram_rdata)
    );

    assign row7s = (COORD_W+1)'(s2_row_reg);
    assign band_end = top7 + {1'b0, eb_reg};
    assign in_band = (row7s >= top7) && (row7s < band_end);

    assign rect_mask = (in_band && (ea_reg != '0))
        ? span_bits(left_reg, {1'b0, left_reg} + {1'b0, ea_reg} - (COORD_W+1)'(1)) : '0;
    assign line_mask = ((row7s == top7) && (left_reg <= ea_reg))
        ? span_bits(left_reg, {1'b0, ea_reg}) : '0;
    assign tri_mask = in_band
        ? span_bits(left_reg, {1'b0, left_reg} + (row7s - top7)) : '0;

    // ring test, one compare pair per column
    always_comb
    begin
        logic [COORD_W-1:0] ycol;
        logic [COORD_W-1:0] dy;
        logic [SQ_W-1:0]    dy2;
        logic [D_W-1:0]     ring_d;
        circ_mask = '0;
        for (int j = 0; j < PIX_W; j++)
        begin
            ycol = COORD_W'(j);
            dy = (ycol >= left_reg) ? (ycol - left_reg) : (left_reg - ycol);
            dy2 = dy * dy;
            ring_d = {1'b0, dx2_reg} + {1'b0, dy2};
            circ_mask[j] = (ring_d >= lo_reg) && (ring_d <= hi_reg);
        end
    end

    always_comb
    begin
        case (cmd_reg)
            CMD_RECT:     draw_mask = rect_mask;
            CMD_LINE:     draw_mask = line_mask;
            CMD_TRIANGLE: draw_mask = tri_mask;
            CMD_CIRCLE:   draw_mask = circ_mask;
            default:      draw_mask = '0;
        endcase
    end

    assign old_row = rvalid_reg ? ram_rdata : '0;
    assign wdata = (old_row | draw_mask) & COL_MASK;
    assign we = s2_valid_reg && (cmd_reg != CMD_DISPLAY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= s2_valid_reg && (cmd_reg == CMD_DISPLAY);
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= IDX_W'(s2_row_reg);
        pix_reg <= old_row & COL_MASK;
        last_reg <= (s2_row_reg == LAST_ROW);
    end

    assign strobe = strobe_reg;
    assign row_index = idx_reg;
    assign row_pixels = pix_reg;
    assign last_row = last_reg;

endmodule

// ===== hdl/bitmap_shape_rasterizer.sv =====
// drawing commands walk every canvas row, one canvas row read-modify-written per cycle
// clear does not make the block busy; unknown command codes are taken and dropped
// display: row words start with row zero, then one row per cycle, last_row on the final row
// throughput is set by the single read and single write port of the canvas memory
// the receiver cannot stall: each row word is on the outputs for exactly one cycle
// rst_n asynchronous: controller goes idle and every canvas row reads as cleared
module bitmap_shape_rasterizer #(
    parameter int CANVAS_ROWS = bsr_pkg::DEF_CANVAS_ROWS,
    parameter int CANVAS_COLS = bsr_pkg::DEF_CANVAS_COLS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bsr_pkg::CMD_W-1:0]     cmd,
    input  logic [bsr_pkg::COORD_W-1:0]   top_row,
    input  logic [bsr_pkg::COORD_W-1:0]   left_col,
    input  logic [bsr_pkg::COORD_W-1:0]   extent_a,
    input  logic [bsr_pkg::COORD_W-1:0]   extent_b,
    output logic                          strobe,
    output logic [bsr_pkg::IDX_W-1:0]     row_index,
    output logic [bsr_pkg::PIX_W-1:0]     row_pixels,
    output logic                          last_row
);

    import bsr_pkg::*;

    `include "bitmap_shape_rasterizer_assert.svh"

    localparam int ROW_W = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;

    ctl_t             ctl;
    logic [ROW_W-1:0] rd_row;

    bsr_ctrl #(
        .CANVAS_ROWS(CANVAS_ROWS),
        .ROW_W      (ROW_W)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .ctl   (ctl),
        .rd_row(rd_row)
    );

    bsr_datapath #(
        .CANVAS_ROWS(CANVAS_ROWS),
        .CANVAS_COLS(CANVAS_COLS),
        .ROW_W      (ROW_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .rd_row    (rd_row),
        .cmd       (cmd),
        .top_row   (top_row),
        .left_col  (left_col),
        .extent_a  (extent_a),
        .extent_b  (extent_b),
        .strobe    (strobe),
        .row_index (row_index),
        .row_pixels(row_pixels),
        .last_row  (last_row)
    );

    // display starts with row zero once it is taken
    `BSR_ASSERT_SAME(a_display_first, clk, rst_n, start && !busy && (cmd == CMD_DISPLAY), ##3 (strobe && (row_index == '0)))
    // rows of a display run come without gaps
    `BSR_ASSERT_NEXT(a_rows_contiguous, clk, rst_n, strobe && !last_row, strobe)
    // a run ends after its last row
    `BSR_ASSERT_NEXT(a_run_ends, clk, rst_n, strobe && last_row, !strobe)

endmodule
